>>> rtl/cpr_pkg.sv
// shared types and constants for the character printer register device
// no dependencies; imported by cpr_core and char_printer_register_device
`default_nettype none

package cpr_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OffsetWidth = 8;
  localparam int unsigned SizeWidth   = 4;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned DelayWidth  = 16;
  localparam int unsigned SlotWidth   = OffsetWidth - 2;
  localparam int unsigned PaddrWidth  = 3;

  localparam logic [DelayWidth-1:0] DelayReset = DelayWidth'(10);
  localparam logic [SizeWidth-1:0]  SizeWord   = SizeWidth'(4);
  localparam logic [DataWidth-1:0]  CmdPrint   = DataWidth'(2);
  localparam logic [DataWidth-1:0]  ReadInvalid = '1;

  // register slots (word offsets)
  localparam logic [SlotWidth-1:0] SlotStatus  = SlotWidth'(0);
  localparam logic [SlotWidth-1:0] SlotCommand = SlotWidth'(1);
  localparam logic [SlotWidth-1:0] SlotData    = SlotWidth'(2);

  // configuration register index
  localparam logic CfgPrintDelay = 1'b0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_READY = 3'd1,
    ST_BUSY  = 3'd3,
    ST_ERROR = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [OffsetWidth-1:0] offset;
    logic [SizeWidth-1:0]   access_size;
    logic [DataWidth-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 print_valid;
    logic [CharWidth-1:0] print_char;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/char_printer_register_device.sv
// top level of the character printer register device: transfer stages and apb port
// depends on cpr_pkg and cpr_core
`default_nettype none

// Character printer register device. Each input transfer is a bus read, a bus
// write or a time tick against three 32-bit registers: status at byte offset 0
// (ready 1, busy 3, error 4), command at 4 and data at 8. Writing command 2
// latches the data byte and starts a countdown of print_delay ticks; on expiry
// the byte comes out with print_valid set, the data register clears and the
// status returns to ready. Every input transfer gives exactly one result
// transfer. One transfer is taken every cycle while the output is not stalled;
// each transfer passes through the input register and then the result register,
// with the register update done in the step between them.
// print_delay is written through the apb port at byte address 0 (reset 10).
module char_printer_register_device (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         opcode_i,
  input  logic [cpr_pkg::OffsetWidth-1:0]    offset_i,
  input  logic [cpr_pkg::SizeWidth-1:0]      access_size_i,
  input  logic [cpr_pkg::DataWidth-1:0]      write_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cpr_pkg::DataWidth-1:0]      read_data_o,
  output logic                               print_valid_o,
  output logic [cpr_pkg::CharWidth-1:0]      print_char_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cpr_pkg::PaddrWidth-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cpr_pkg::*;

  // input register
  logic    in_valid_q;
  item_t   item_q;
  // result register
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;

  logic [DelayWidth-1:0] delay_q;

  logic out_free;
  logic advance;
  logic in_take;
  logic cfg_write;
  logic cfg_hit;

  // result register can take a new value when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // input register frees when its content moves on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode      <= opcode_i;
      item_q.offset      <= offset_i;
      item_q.access_size <= access_size_i;
      item_q.write_data  <= write_data_i;
    end
  end

  // register state and per-transfer logic, stepped as the item moves on
  cpr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (item_q),
    .print_delay_i (delay_q),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = result_q.read_data;
  assign print_valid_o = result_q.print_valid;
  assign print_char_o  = result_q.print_char;

  // apb configuration: single register, no wait states
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == CfgPrintDelay);
  assign cfg_write = psel && penable && pwrite && cfg_hit;
  assign prdata    = cfg_hit ? 32'(delay_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_write) begin
      delay_q <= pwdata[DelayWidth-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/cpr_core.sv
// device registers and the per-transfer decode, read, write and tick logic
// depends on cpr_pkg
`default_nettype none

module cpr_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  cpr_pkg::item_t                  item_i,
  input  logic [cpr_pkg::DelayWidth-1:0]  print_delay_i,
  output cpr_pkg::result_t                result_o
);
  import cpr_pkg::*;

  status_e               status_q, status_d;
  logic [DataWidth-1:0]  command_q, command_d;
  logic [DataWidth-1:0]  data_q, data_d;
  logic [DelayWidth-1:0] count_q, count_d;
  logic [CharWidth-1:0]  pending_q, pending_d;

  logic [SlotWidth-1:0] slot;
  logic                 size_ok;
  logic                 busy;

  assign slot    = item_i.offset[OffsetWidth-1:2];
  assign size_ok = (item_i.access_size == SizeWord);
  assign busy    = (status_q == ST_BUSY);

  always_comb begin
    status_d  = status_q;
    command_d = command_q;
    data_d    = data_q;
    count_d   = count_q;
    pending_d = pending_q;
    result_o  = '0;
    case (opcode_e'(item_i.opcode))
      OP_READ: begin
        if (!size_ok || slot > SlotData) begin
          result_o.read_data = ReadInvalid;
        end else if (slot == SlotStatus) begin
          result_o.read_data = DataWidth'(status_q);
        end else if (slot == SlotCommand) begin
          result_o.read_data = command_q;
        end else begin
          result_o.read_data = data_q;
        end
      end
      OP_WRITE: begin
        if (size_ok && !busy) begin
          if (slot == SlotData) begin
            data_d = item_i.write_data;
          end else if (slot == SlotCommand) begin
            command_d = item_i.write_data;
            if (item_i.write_data == CmdPrint) begin
              pending_d = data_q[CharWidth-1:0];
              status_d  = ST_BUSY;
              count_d   = print_delay_i;
            end else begin
              status_d = ST_ERROR;
            end
          end
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (count_q <= DelayWidth'(1)) begin
            count_d              = '0;
            result_o.print_valid = 1'b1;
            result_o.print_char  = pending_q;
            data_d               = '0;
            status_d             = ST_READY;
          end else begin
            count_d = count_q - DelayWidth'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_READY;
      command_q <= '0;
      data_q    <= '0;
      count_q   <= '0;
      pending_q <= '0;
    end else if (step_i) begin
      status_q  <= status_d;
      command_q <= command_d;
      data_q    <= data_d;
      count_q   <= count_d;
      pending_q <= pending_d;
    end
  end

endmodule

`default_nettype wire
